>>> hdl/bit_field_buffer_store_assert.svh
// Assertion macros for the RTL of the bit field buffer store; bfbs_back includes them.
`ifndef BIT_FIELD_BUFFER_STORE_ASSERT_SVH
`define BIT_FIELD_BUFFER_STORE_ASSERT_SVH

// The expression holds at every clock edge outside reset.
`define BFBS_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define BFBS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BFBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/bfbs_pkg.sv
package bfbs_pkg;

  localparam int unsigned CapacityBytes = 256;
  localparam int unsigned CapacityBits  = CapacityBytes * 8;
  localparam int unsigned MaxFieldBits  = 32;
  localparam int unsigned WordBits      = 32;
  localparam int unsigned NumWords      = CapacityBytes / 4;
  localparam int unsigned ByteIdxW      = $clog2(CapacityBytes);
  localparam int unsigned WordIdxW      = $clog2(NumWords);
  localparam int unsigned BankAddrW     = WordIdxW - 1;
  localparam int unsigned BankDepth     = NumWords / 2;
  localparam int unsigned QueueDepth    = 2;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned QCntW         = $clog2(QueueDepth + 1);

  localparam logic [2:0] CmdRead    = 3'd0;
  localparam logic [2:0] CmdPeek    = 3'd1;
  localparam logic [2:0] CmdReadBit = 3'd2;
  localparam logic [2:0] CmdWrite   = 3'd3;
  localparam logic [2:0] CmdResize  = 3'd4;
  localparam logic [2:0] CmdClear   = 3'd5;
  localparam logic [2:0] CmdReset   = 3'd6;

  typedef struct packed {
    logic [2:0]  command;
    logic [15:0] position;
    logic [5:0]  field_length;
    logic [31:0] write_value;
    logic [11:0] new_length;
  } item_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic [16:0] next_position;
    logic [11:0] length_bits;
    logic [11:0] write_end_bits;
    logic        status;
  } res_t;

  typedef struct packed {
    logic [2:0]          command;
    logic [15:0]         position;
    logic [5:0]          n;
    logic [31:0]         write_value;
    logic [16:0]         end_pos;
    logic [11:0]         new_len;
    logic [ByteIdxW:0]   new_bytes;
    logic                fail;
  } op_t;

endpackage

>>> hdl/bfbs_front.sv
module bfbs_front (
  input  bfbs_pkg::item_t item_i,
  output bfbs_pkg::op_t   op_o
);
  import bfbs_pkg::*;

  logic [5:0]  n_sat;
  logic [16:0] end_pos;
  logic [16:0] end_rnd;
  logic [12:0] nl_rnd;

  always_comb begin
    n_sat = (item_i.field_length > 6'(MaxFieldBits)) ? 6'(MaxFieldBits)
                                                      : item_i.field_length;
    if (item_i.command == CmdReadBit) begin
      n_sat = 6'd1;
    end
    end_pos = 17'(item_i.position) + 17'(n_sat);
    end_rnd = end_pos + 17'd7;
    nl_rnd  = 13'(item_i.new_length) + 13'd7;

    op_o.command     = item_i.command;
    op_o.position    = item_i.position;
    op_o.n           = n_sat;
    op_o.write_value = item_i.write_value;
    op_o.end_pos     = end_pos;
    op_o.new_len     = item_i.new_length;
    op_o.new_bytes   = nl_rnd[ByteIdxW+3:3];
    op_o.fail        = 1'b0;
    case (item_i.command)
      CmdWrite: begin
        op_o.new_len   = end_pos[11:0];
        op_o.new_bytes = end_rnd[ByteIdxW+3:3];
        op_o.fail      = end_pos > 17'(CapacityBits);
      end
      CmdResize: begin
        op_o.fail = item_i.new_length > 12'(CapacityBits);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hdl/bfbs_queue.sv
module bfbs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bfbs_pkg::op_t data_i,
  input  logic          pop_i,
  output bfbs_pkg::op_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import bfbs_pkg::*;

  op_t              entries_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = count_q == QCntW'(QueueDepth);
  assign empty_o = count_q == '0;
  assign data_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/bfbs_back.sv
`include "bit_field_buffer_store_assert.svh"

module bfbs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bfbs_pkg::op_t head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output bfbs_pkg::res_t res_o,
  output logic          res_valid_o
);
  import bfbs_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StExec = 1'b1;

  logic state_q, state_d;

  logic [WordBits-1:0] mem_ev [BankDepth];
  logic [WordBits-1:0] mem_od [BankDepth];
  logic [WordBits-1:0] rd_ev_q, rd_od_q;

  logic [CapacityBytes-1:0] holds_q, holds_d;
  logic [11:0]              length_q, length_d;
  logic [11:0]              hwe_q, hwe_d;
  logic [ByteIdxW:0]        alloc_q, alloc_d;

  op_t                  op_q;
  logic [BankAddrW-1:0] ev_addr_q, ev_addr_d, od_addr_q, od_addr_d;
  logic [6:0]           lim_q, lim_d;
  logic [7:0]           bvalid_q, bvalid_d;
  logic                 in_len_q, in_len_d;
  logic                 grow_q, grow_d;
  logic                 hwe_up_q, hwe_up_d;
  logic [ByteIdxW:0]    lo_q, lo_d, hi_q, hi_d;

  res_t res_q, res_d;
  logic res_valid_q;

  logic                 issue;
  logic [WordIdxW-1:0]  head_w0;
  logic [ByteIdxW-1:0]  head_wbase;
  logic [15:0]          head_base;
  logic [11:0]          lim_diff;

  logic [WordBits-1:0]  word0, word1;
  logic [63:0]          window, lenmask, bytemask, rd_shift;
  logic [31:0]          rd_val;
  logic [5:0]           sh_r;
  logic [4:0]           off;
  logic [31:0]          val_left, fmask_left;
  logic [63:0]          wd64, fm64, wm64;
  logic [7:0]           touched, h_eff;
  logic [ByteIdxW-1:0]  wbase;
  logic [ByteIdxW-1:0]  idx_k;
  logic                 wr_ok, rs_ok, clr_en, we;
  logic [WordBits-1:0]  ev_wdata, ev_wmask, od_wdata, od_wmask;

  assign issue       = (state_q == StIdle) && !empty_i;
  assign pop_o       = issue;
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // Issue cycle: address both banks and capture the masks for the 64-bit window.
  always_comb begin
    head_w0    = head_i.position[5 +: WordIdxW];
    od_addr_d  = head_w0[WordIdxW-1:1];
    ev_addr_d  = head_w0[WordIdxW-1:1] + BankAddrW'(head_w0[0]);
    head_wbase = {head_w0, 2'b00};
    head_base  = {head_i.position[15:5], 5'b00000};
    lim_diff   = length_q - head_base[11:0];
    if (head_base >= 16'(length_q)) begin
      lim_d = 7'd0;
    end else if (lim_diff >= 12'd64) begin
      lim_d = 7'd64;
    end else begin
      lim_d = lim_diff[6:0];
    end
    for (int k = 0; k < 8; k++) begin
      bvalid_d[k] = holds_q[head_wbase + ByteIdxW'(k)];
    end
    in_len_d = 17'(head_i.position) < 17'(length_q);
    grow_d   = head_i.end_pos > 17'(length_q);
    hwe_up_d = head_i.end_pos > 17'(hwe_q);
    lo_d     = (head_i.new_bytes < alloc_q) ? head_i.new_bytes : alloc_q;
    hi_d     = (head_i.new_bytes < alloc_q) ? alloc_q : head_i.new_bytes;
  end

  // Execute cycle: extract the field, merge the write and update the bookkeeping.
  always_comb begin
    off    = op_q.position[4:0];
    sh_r   = 6'(WordBits) - op_q.n;
    word0  = op_q.position[5] ? rd_od_q : rd_ev_q;
    word1  = op_q.position[5] ? rd_ev_q : rd_od_q;
    window = {word0, word1};
    lenmask = ~({64{1'b1}} >> lim_q);
    for (int k = 0; k < 8; k++) begin
      bytemask[63-8*k -: 8] = {8{bvalid_q[k]}};
    end
    rd_shift = (window & lenmask & bytemask) << off;
    rd_val   = rd_shift[63:32] >> sh_r;

    wr_ok  = (op_q.command == CmdWrite) && !op_q.fail;
    rs_ok  = (op_q.command == CmdResize) && !op_q.fail;
    clr_en = rs_ok || (wr_ok && grow_q);
    we     = wr_ok;

    val_left   = op_q.write_value << sh_r;
    fmask_left = ~({32{1'b1}} >> op_q.n);
    wd64       = {val_left, 32'd0} >> off;
    fm64       = {fmask_left, 32'd0} >> off;
    wbase      = {op_q.position[5 +: WordIdxW], 2'b00};
    wm64       = fm64;
    for (int k = 0; k < 8; k++) begin
      idx_k      = wbase + ByteIdxW'(k);
      touched[k] = |fm64[63-8*k -: 8];
      h_eff[k]   = bvalid_q[k] &&
                   !(clr_en && ({1'b0, idx_k} >= lo_q) && ({1'b0, idx_k} < hi_q));
      if (touched[k] && !h_eff[k]) begin
        wm64[63-8*k -: 8] = 8'hFF;
      end
    end
    ev_wdata = op_q.position[5] ? wd64[31:0] : wd64[63:32];
    ev_wmask = op_q.position[5] ? wm64[31:0] : wm64[63:32];
    od_wdata = op_q.position[5] ? wd64[63:32] : wd64[31:0];
    od_wmask = op_q.position[5] ? wm64[63:32] : wm64[31:0];

    holds_d  = holds_q;
    length_d = length_q;
    hwe_d    = hwe_q;
    alloc_d  = alloc_q;
    if (clr_en) begin
      for (int i = 0; i < CapacityBytes; i++) begin
        if ((ByteIdxW+1)'(i) >= lo_q && (ByteIdxW+1)'(i) < hi_q) begin
          holds_d[i] = 1'b0;
        end
      end
      alloc_d  = op_q.new_bytes;
      length_d = op_q.new_len;
    end
    if (wr_ok) begin
      for (int k = 0; k < 8; k++) begin
        if (touched[k]) begin
          holds_d[wbase + ByteIdxW'(k)] = 1'b1;
        end
      end
      if (hwe_up_q) begin
        hwe_d = op_q.end_pos[11:0];
      end
    end

    res_d.read_value    = 32'd0;
    res_d.next_position = 17'(op_q.position);
    res_d.status        = op_q.fail;
    case (op_q.command)
      CmdRead: begin
        res_d.read_value    = rd_val;
        res_d.next_position = op_q.end_pos;
      end
      CmdPeek: begin
        res_d.read_value = rd_val;
      end
      CmdReadBit: begin
        res_d.read_value = rd_val;
        if (in_len_q) begin
          res_d.next_position = op_q.end_pos;
        end
      end
      CmdWrite: begin
        if (!op_q.fail) begin
          res_d.next_position = op_q.end_pos;
        end
      end
      CmdClear: begin
        length_d = 12'd0;
      end
      CmdReset: begin
        length_d = 12'd0;
        hwe_d    = 12'd0;
        holds_d  = '0;
      end
      default: begin
      end
    endcase
    res_d.length_bits    = length_d;
    res_d.write_end_bits = hwe_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:  state_d = issue ? StExec : StIdle;
      StExec:  state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      res_valid_q <= 1'b0;
      holds_q     <= '0;
      length_q    <= '0;
      hwe_q       <= '0;
      alloc_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= state_q == StExec;
      if (state_q == StExec) begin
        holds_q  <= holds_d;
        length_q <= length_d;
        hwe_q    <= hwe_d;
        alloc_q  <= alloc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      op_q      <= head_i;
      ev_addr_q <= ev_addr_d;
      od_addr_q <= od_addr_d;
      lim_q     <= lim_d;
      bvalid_q  <= bvalid_d;
      in_len_q  <= in_len_d;
      grow_q    <= grow_d;
      hwe_up_q  <= hwe_up_d;
      lo_q      <= lo_d;
      hi_q      <= hi_d;
    end
    if (state_q == StExec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_ev_q <= mem_ev[ev_addr_d];
      rd_od_q <= mem_od[od_addr_d];
    end
    if ((state_q == StExec) && we) begin
      for (int b = 0; b < WordBits; b++) begin
        if (ev_wmask[b]) begin
          mem_ev[ev_addr_q][b] <= ev_wdata[b];
        end
        if (od_wmask[b]) begin
          mem_od[od_addr_q][b] <= od_wdata[b];
        end
      end
    end
  end

  `BFBS_ASSERT_ALWAYS(a_length_cap, length_q <= 12'(CapacityBits), "Length exceeds capacity.")
  `BFBS_ASSERT_ALWAYS(a_alloc_cap, alloc_q <= (ByteIdxW+1)'(CapacityBytes), "Allocation too large.")
  `BFBS_ASSERT_NEXT(a_exec_result, state_q == StExec, res_valid_q, "Execute gave no result.")
  `BFBS_ASSERT_NEXT(a_idle_quiet, state_q == StIdle, !res_valid_q, "Result without execute.")
  `BFBS_ASSERT_IMPLIES(a_fail_keeps, res_valid_q && res_q.status, $stable(length_q) && $stable(hwe_q), "Failed command changed state.")

endmodule

>>> hdl/bit_field_buffer_store.sv
// Bit field buffer store. A transaction is accepted at a rising edge with start high
// and busy low; it enters a two-entry command queue, and the back end executes one
// command at a time: an issue step reads the two 32-bit memory banks that hold
// the 64-bit window around the position, an execute step merges, extracts and
// updates the length bookkeeping. With an empty queue the result is registered at
// the end of the execute step and shown on res_o with res_valid_o high for exactly
// one cycle; the receiver must take it then, since results cannot be held off. The
// back end does not issue a new command before the current one has executed;
// busy rises while the queue is full.
module bit_field_buffer_store (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  bfbs_pkg::item_t item_i,
  output bfbs_pkg::res_t  res_o,
  output logic            res_valid_o
);
  import bfbs_pkg::*;

  op_t  front_op;
  op_t  head_op;
  logic push, pop, full, empty;

  assign busy = full;
  assign push = start && !full;

  bfbs_front u_front (
    .item_i (item_i),
    .op_o   (front_op)
  );

  bfbs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_op),
    .pop_i   (pop),
    .data_o  (head_op),
    .full_o  (full),
    .empty_o (empty)
  );

  bfbs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_op),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_o       (res_o),
    .res_valid_o (res_valid_o)
  );

endmodule

>>> test/bit_field_buffer_store_test.sv
`timescale 1ns / 1ps

module bit_field_buffer_store_test;
  import bfbs_pkg::*;

  localparam logic [2:0] CmdUnused = 3'd7;
  localparam int unsigned CycleLimit = 300000;

  typedef struct {
    item_t it;
    bit    hold;
    int    idle_pct;
  } slot_t;

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  item_t item_i = '0;
  res_t  res_o;
  logic  res_valid_o;

  slot_t commands_due[$];
  res_t  replies_due[$];

  logic [7:0]  byte_image[CapacityBytes];
  bit          byte_live[CapacityBytes];
  int unsigned fill_bits;
  int unsigned top_written;
  int unsigned bytes_held;

  int          fault_count = 0;
  int unsigned cycle_count = 0;
  int          idle_now = 0;
  bit          hold_next = 1'b0;
  int unsigned recent_pos = 0;

  bit_field_buffer_store u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .res_o      (res_o),
    .res_valid_o(res_valid_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic bit fetch_bit(int unsigned p);
    int unsigned idx;
    idx = p >> 3;
    if (p >= fill_bits || idx >= CapacityBytes || !byte_live[idx]) return 1'b0;
    return byte_image[idx][7 - (p % 8)];
  endfunction

  function automatic void store_bit(int unsigned p, bit b);
    int unsigned idx;
    idx = p >> 3;
    if (idx >= CapacityBytes) return;
    if (!byte_live[idx]) begin
      byte_image[idx] = 8'h00;
      byte_live[idx] = 1'b1;
    end
    byte_image[idx][7 - (p % 8)] = b;
  endfunction

  function automatic logic [31:0] fetch_field(int unsigned p, int unsigned n);
    logic [31:0] acc;
    acc = '0;
    for (int unsigned i = 0; i < n; i++) acc = {acc[30:0], fetch_bit(p + i)};
    return acc;
  endfunction

  function automatic void resize_store(int unsigned nbits);
    int unsigned nb;
    int unsigned lo;
    int unsigned hi;
    nb = (nbits + 7) >> 3;
    lo = (nb < bytes_held) ? nb : bytes_held;
    hi = (nb < bytes_held) ? bytes_held : nb;
    for (int unsigned i = lo; i < hi && i < CapacityBytes; i++) byte_live[i] = 1'b0;
    bytes_held = nb;
    fill_bits = nbits;
  endfunction

  // Applies one accepted command to the shadow store and queues the reply it must produce.
  function automatic void run_command(item_t it);
    int unsigned pos;
    int unsigned n;
    int unsigned fin;
    int unsigned np;
    logic [31:0] rv;
    bit          st;
    res_t        reply;
    pos = it.position;
    n = (it.field_length > MaxFieldBits) ? MaxFieldBits : it.field_length;
    rv = '0;
    np = pos;
    st = 1'b0;
    case (it.command)
      CmdRead: begin
        rv = fetch_field(pos, n);
        np = pos + n;
      end
      CmdPeek: begin
        rv = fetch_field(pos, n);
      end
      CmdReadBit: begin
        if (pos < fill_bits) begin
          rv = {31'd0, fetch_bit(pos)};
          np = pos + 1;
        end
      end
      CmdWrite: begin
        fin = pos + n;
        if (fin > CapacityBits) begin
          st = 1'b1;
        end else begin
          if (fin > fill_bits) resize_store(fin);
          if (fin > top_written) top_written = fin;
          for (int unsigned i = 0; i < n; i++) store_bit(pos + i, it.write_value[n - 1 - i]);
          np = fin;
        end
      end
      CmdResize: begin
        if (it.new_length > CapacityBits) st = 1'b1;
        else resize_store(it.new_length);
      end
      CmdClear: begin
        fill_bits = 0;
      end
      CmdReset: begin
        fill_bits = 0;
        top_written = 0;
        for (int i = 0; i < CapacityBytes; i++) byte_live[i] = 1'b0;
      end
      default: begin
      end
    endcase
    reply.read_value = rv;
    reply.next_position = np[16:0];
    reply.length_bits = fill_bits[11:0];
    reply.write_end_bits = top_written[11:0];
    reply.status = st;
    replies_due.push_back(reply);
  endfunction

  function automatic void queue_cmd(logic [2:0] c, int unsigned p, int unsigned n,
                                    logic [31:0] v, int unsigned nl);
    slot_t s;
    s.it.command = c;
    s.it.position = p[15:0];
    s.it.field_length = n[5:0];
    s.it.write_value = v;
    s.it.new_length = nl[11:0];
    s.hold = hold_next;
    s.idle_pct = idle_now;
    hold_next = 1'b0;
    commands_due.push_back(s);
  endfunction

  // Mostly in-range traffic clustered around recent positions, with some wild values.
  function automatic void queue_random();
    int unsigned pick;
    int unsigned p;
    int unsigned n;
    int unsigned nl;
    logic [2:0]  c;
    pick = $urandom_range(99);
    if (pick < 30) c = CmdWrite;
    else if (pick < 50) c = CmdRead;
    else if (pick < 62) c = CmdPeek;
    else if (pick < 74) c = CmdReadBit;
    else if (pick < 83) c = CmdResize;
    else if (pick < 88) c = CmdClear;
    else if (pick < 91) c = CmdReset;
    else if (pick < 97) c = 3'($urandom_range(7));
    else c = CmdUnused;
    pick = $urandom_range(99);
    if (pick < 45) p = (recent_pos + $urandom_range(64)) % CapacityBits;
    else if (pick < 60) p = $urandom_range(255);
    else if (pick < 92) p = $urandom_range(CapacityBits - 1);
    else p = $urandom_range(65535);
    n = ($urandom_range(99) < 85) ? $urandom_range(32) : $urandom_range(63);
    nl = ($urandom_range(99) < 88) ? $urandom_range(CapacityBits) : $urandom_range(4095);
    if (c == CmdWrite) recent_pos = p;
    queue_cmd(c, p, n, $urandom, nl);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      item_i <= '0;
    end else begin
      if (start && !busy) run_command(item_i);
      if (!start || !busy) begin
        if (commands_due.size() != 0 && !(commands_due[0].hold && replies_due.size() != 0)
            && $urandom_range(99) >= commands_due[0].idle_pct) begin
          start <= 1'b1;
          item_i <= commands_due[0].it;
          void'(commands_due.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (replies_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("unexpected result: %p", res_o);
      end else begin
        want = replies_due.pop_front();
        if (res_o.read_value !== want.read_value || res_o.next_position !== want.next_position
            || res_o.length_bits !== want.length_bits
            || res_o.write_end_bits !== want.write_end_bits || res_o.status !== want.status) begin
          fault_count++;
          if (fault_count <= 10) $display("mismatch: expected %p, got %p", want, res_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    idle_now = 21;
    queue_cmd(CmdRead, 0, 32, 32'h0, 0);
    queue_cmd(CmdReadBit, 0, 1, 32'h0, 0);
    queue_cmd(CmdWrite, 0, 32, 32'hDEADBEEF, 0);
    queue_cmd(CmdPeek, 4, 32, 32'h0, 0);
    queue_cmd(CmdRead, 20, 63, 32'h0, 0);
    queue_cmd(CmdReadBit, 31, 0, 32'h0, 0);
    queue_cmd(CmdReadBit, 32, 0, 32'h0, 0);
    queue_cmd(CmdWrite, CapacityBits - 8, 8, 32'hFFFFFFFF, 0);
    queue_cmd(CmdWrite, CapacityBits - 7, 8, 32'hFFFFFFFF, 0);
    queue_cmd(CmdWrite, 65535, 63, 32'hFFFFFFFF, 4095);
    queue_cmd(CmdResize, 0, 0, 32'h0, CapacityBits);
    queue_cmd(CmdResize, 0, 0, 32'h0, CapacityBits + 1);
    queue_cmd(CmdResize, 65535, 63, 32'hFFFFFFFF, 4095);
    queue_cmd(CmdResize, 0, 0, 32'h0, 16);
    queue_cmd(CmdResize, 0, 0, 32'h0, CapacityBits);
    queue_cmd(CmdRead, CapacityBits - 16, 16, 32'h0, 0);
    queue_cmd(CmdRead, 0, 32, 32'h0, 0);
    queue_cmd(CmdClear, 0, 0, 32'h0, 0);
    queue_cmd(CmdWrite, 300, 0, 32'h0, 0);
    queue_cmd(CmdRead, 0, 32, 32'h0, 0);
    queue_cmd(CmdReset, 0, 0, 32'h0, 0);
    queue_cmd(CmdRead, 0, 32, 32'h0, 0);
    queue_cmd(CmdUnused, 65535, 63, 32'hFFFFFFFF, 4095);
    queue_cmd(CmdPeek, 0, 0, 32'h0, 0);
    queue_cmd(CmdResize, 0, 0, 32'h0, 0);
    for (int i = 0; i < 180; i++) begin
      if (i == 90) hold_next = 1'b1;
      queue_random();
    end
    idle_now = 74;
    hold_next = 1'b1;
    for (int i = 0; i < 180; i++) queue_random();
    idle_now = 0;
    hold_next = 1'b1;
    for (int i = 0; i < 190; i++) queue_random();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (commands_due.size() != 0 || start) @(posedge clk_i);
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fault_count == 0 && replies_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bfbs_pkg.sv
hdl/bfbs_front.sv
hdl/bfbs_queue.sv
hdl/bfbs_back.sv
hdl/bit_field_buffer_store.sv
test/bit_field_buffer_store_test.sv
